// ===== design/ppd_pkg.sv =====
// shared constants for the point to plane distance pipeline
// no dependencies
package ppd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_CHUNK_DEF   = 32;
  localparam int GAP_WIDTH       = 32;
  localparam int PRE_STAGES      = 9;

endpackage

// ===== design/point_plane_distance_unit.sv =====
// point to plane distance: 9 arithmetic stages plus one stage per gap bit lie between
// the accepting edge and the first edge that can take the result
// one item per cycle while no result is held; the whole pipeline advances together
// a held result stalls every stage
// synchronous active low reset clears all valid bits; data registers are not reset
// depends on ppd_pkg and ppd_mul
module point_plane_distance_unit #(
  parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF,
  parameter int MUL_CHUNK   = ppd_pkg::MUL_CHUNK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_edge_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_edge_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_probe_x,
  input  logic signed [COORD_WIDTH-1:0] in_probe_y,
  input  logic signed [COORD_WIDTH-1:0] in_probe_z,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_x,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_y,
  input  logic signed [COORD_WIDTH-1:0] in_anchor_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ppd_pkg::GAP_WIDTH-1:0] out_gap,
  output logic                          out_degenerate
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int NW   = 2 * W + 1;
  localparam int P2W  = NW + DW;
  localparam int S2W  = 2 * NW;
  localparam int DOTW = P2W + 2;
  localparam int SQW  = S2W + 2;
  localparam int MW   = DOTW + 1;
  localparam int DSQW = 2 * MW;
  localparam int GW   = ppd_pkg::GAP_WIDTH;
  localparam int TW   = SQW + GW;
  localparam int EA   = DSQW;
  localparam int EB   = SQW + 2 * GW;
  localparam int EW   = ((EA > EB) ? EA : EB) + 2;
  localparam int PS   = ppd_pkg::PRE_STAGES;
  localparam int NV   = PS + GW;

  logic adv;
  logic [NV-1:0] vld_r;

  logic signed [W-1:0]  ea [3];
  logic signed [W-1:0]  eb [3];
  logic signed [DW-1:0] dif [3];
  logic signed [DW-1:0] dif0_r [3];
  logic signed [DW-1:0] dif1_r [3];
  logic signed [DW-1:0] dif2_r [3];
  logic signed [2*W-1:0] pa [3];
  logic signed [2*W-1:0] pb [3];
  logic signed [NW-1:0]  nrm_r [3];
  logic signed [P2W-1:0] pd [3];
  logic signed [S2W-1:0] pn [3];
  logic signed [DOTW-1:0] dot_r;
  logic [SQW-1:0] sq_r;
  logic [SQW-1:0] sq6_r;
  logic [SQW-1:0] sq7_r;
  logic [SQW-1:0] sq8_r;
  logic zero6_r;
  logic zero7_r;
  logic zero8_r;
  logic [DOTW-1:0] mag_r;
  logic signed [DSQW-1:0] dsq;

  logic [EW-1:0]  rem_r  [GW];
  logic [TW-1:0]  tg_r   [GW];
  logic [GW-1:0]  g_r    [GW];
  logic [SQW-1:0] sqi_r  [GW];
  logic           zeroi_r [GW];

  assign adv      = !vld_r[NV-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  assign ea[0] = in_edge_a_x;
  assign ea[1] = in_edge_a_y;
  assign ea[2] = in_edge_a_z;
  assign eb[0] = in_edge_b_x;
  assign eb[1] = in_edge_b_y;
  assign eb[2] = in_edge_b_z;
  assign dif[0] = DW'(in_anchor_x) - DW'(in_probe_x);
  assign dif[1] = DW'(in_anchor_y) - DW'(in_probe_y);
  assign dif[2] = DW'(in_anchor_z) - DW'(in_probe_z);

  for (genvar i = 0; i < 3; i++) begin : g_vec
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    ppd_mul #(.AW(W), .BW(W), .CH(MUL_CHUNK)) u_mul_pa (
      .clk(clk), .en(adv), .a(ea[J]), .b(eb[K]), .p(pa[i])
    );
    ppd_mul #(.AW(W), .BW(W), .CH(MUL_CHUNK)) u_mul_pb (
      .clk(clk), .en(adv), .a(eb[J]), .b(ea[K]), .p(pb[i])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        dif0_r[i] <= dif[i];
        dif1_r[i] <= dif0_r[i];
        dif2_r[i] <= dif1_r[i];
        nrm_r[i]  <= NW'(pa[i]) - NW'(pb[i]);
      end
    end

    ppd_mul #(.AW(NW), .BW(DW), .CH(MUL_CHUNK)) u_mul_dot (
      .clk(clk), .en(adv), .a(nrm_r[i]), .b(dif2_r[i]), .p(pd[i])
    );
    ppd_mul #(.AW(NW), .BW(NW), .CH(MUL_CHUNK)) u_mul_sq (
      .clk(clk), .en(adv), .a(nrm_r[i]), .b(nrm_r[i]), .p(pn[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r   <= DOTW'(pd[0]) + DOTW'(pd[1]) + DOTW'(pd[2]);
      sq_r    <= SQW'($unsigned(pn[0])) + SQW'($unsigned(pn[1])) + SQW'($unsigned(pn[2]));
      mag_r   <= dot_r[DOTW-1] ? DOTW'(-dot_r) : DOTW'(dot_r);
      sq6_r   <= sq_r;
      zero6_r <= (sq_r == '0);
      sq7_r   <= sq6_r;
      zero7_r <= zero6_r;
      sq8_r   <= sq7_r;
      zero8_r <= zero7_r;
    end
  end

  ppd_mul #(.AW(MW), .BW(MW), .CH(MUL_CHUNK)) u_mul_dsq (
    .clk(clk), .en(adv),
    .a($signed({1'b0, mag_r})), .b($signed({1'b0, mag_r})), .p(dsq)
  );

  for (genvar k = 0; k < GW; k++) begin : g_bit
    localparam int B = GW - 1 - k;
    logic [EW-1:0]  rem_in;
    logic [TW-1:0]  tg_in;
    logic [GW-1:0]  g_in;
    logic [SQW-1:0] sq_in;
    logic           zero_in;
    logic [EW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in  = EW'($unsigned(dsq));
      assign tg_in   = '0;
      assign g_in    = '0;
      assign sq_in   = sq8_r;
      assign zero_in = zero8_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign tg_in   = tg_r[k-1];
      assign g_in    = g_r[k-1];
      assign sq_in   = sqi_r[k-1];
      assign zero_in = zeroi_r[k-1];
    end

    assign trial = rem_in - (EW'(tg_in) << (B + 1)) - (EW'(sq_in) << (2 * B));
    assign take  = !trial[EW-1];

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]   <= take ? trial : rem_in;
        tg_r[k]    <= take ? tg_in + (TW'(sq_in) << B) : tg_in;
        g_r[k]     <= take ? (g_in | (GW'(1) << B)) : g_in;
        sqi_r[k]   <= sq_in;
        zeroi_r[k] <= zero_in;
      end
    end
  end

  assign out_valid      = vld_r[NV-1];
  assign out_degenerate = zeroi_r[GW-1];
  assign out_gap        = zeroi_r[GW-1] ? '0 : g_r[GW-1];

`ifndef SYNTH
  a_degen_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_gap == '0)
    else $error("degenerate item with nonzero gap");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid survived reset");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[NV-2] |=> out_valid)
    else $error("item lost at last stage");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");
`endif

endmodule

// ===== design/ppd_mul.sv =====
// two stage signed multiplier built from chunk partial products
// depends on nothing; chunk width comes from the instantiating module
module ppd_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int CH = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int XA = NA * CH;
  localparam int XB = NB * CH;
  localparam int XW = XA + XB;
  localparam int PPW = 2 * CH + 2;

  logic signed [XA-1:0]  a_ext;
  logic signed [XB-1:0]  b_ext;
  logic signed [PPW-1:0] pp_r [NA][NB];
  logic signed [XW-1:0]  sum_nxt;
  logic signed [AW+BW-1:0] p_r;

  assign a_ext = XA'(a);
  assign b_ext = XB'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= PPW'($signed({(i == NA - 1) ? a_ext[XA-1] : 1'b0, a_ext[i*CH +: CH]})
                      * $signed({(j == NB - 1) ? b_ext[XB-1] : 1'b0, b_ext[j*CH +: CH]}));
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (XW'(pp_r[i][j]) <<< (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum_nxt[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule
